>>> sv/pointer_event_aggregator_assert.svh
// Assertion macros shared by the pointer event aggregator RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef POINTER_EVENT_AGGREGATOR_ASSERT_SVH
`define POINTER_EVENT_AGGREGATOR_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define PEA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define PEA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/pea_pkg.sv
// Package for the pointer event aggregator: request kinds, event codes, item types.
// No dependencies; used by the top level and the testbench.
package pea_pkg;

   localparam int MAX_HANDLES = 4;
   localparam int SLOTS       = 4;

   typedef enum logic [1:0] {
      REQ_EVENT      = 2'd0,
      REQ_CONNECT    = 2'd1,
      REQ_DISCONNECT = 2'd2
   } req_kind_type;

   // Event types.
   localparam logic [4:0] EV_SYN = 5'd0;
   localparam logic [4:0] EV_KEY = 5'd1;
   localparam logic [4:0] EV_REL = 5'd2;
   localparam logic [4:0] EV_ABS = 5'd3;

   // Event codes.
   localparam logic [9:0] SYN_FRAME     = 10'd0;
   localparam logic [9:0] BTN_PRIMARY   = 10'd272;
   localparam logic [9:0] BTN_SECONDARY = 10'd273;
   localparam logic [9:0] BTN_MID       = 10'd274;
   localparam logic [9:0] BTN_FINGER    = 10'd325;
   localparam logic [9:0] BTN_CONTACT   = 10'd330;
   localparam logic [9:0] REL_X         = 10'd0;
   localparam logic [9:0] REL_Y         = 10'd1;
   localparam logic [9:0] REL_SCROLL    = 10'd8;
   localparam logic [9:0] ABS_X         = 10'd0;
   localparam logic [9:0] ABS_Y         = 10'd1;
   localparam logic [9:0] ABS_MT_X      = 10'd53;
   localparam logic [9:0] ABS_MT_Y      = 10'd54;

   // Tracked position slots of one handle.
   localparam logic [1:0] SLOT_ABS_X = 2'd0;
   localparam logic [1:0] SLOT_ABS_Y = 2'd1;
   localparam logic [1:0] SLOT_MT_X  = 2'd2;
   localparam logic [1:0] SLOT_MT_Y  = 2'd3;

   // Button bit positions.
   localparam logic [1:0] BIT_LEFT   = 2'd0;
   localparam logic [1:0] BIT_RIGHT  = 2'd1;
   localparam logic [1:0] BIT_MIDDLE = 2'd2;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [1:0]         handle_id;
      logic [4:0]         ev_type;
      logic [9:0]         ev_code;
      logic signed [31:0] ev_value;
      logic               pointer_capable;
   } req_item_type;

   typedef struct packed {
      logic               connected;
      logic [7:0]         device_total;
      logic               left_pressed;
      logic               right_pressed;
      logic               middle_pressed;
      logic signed [31:0] motion_x;
      logic signed [31:0] motion_y;
      logic signed [31:0] wheel_motion;
      logic               log_flag;
      logic               connect_ok;
   } rsp_item_type;

endpackage

>>> sv/pea_if.sv
// Valid/ready channel interfaces for the pointer event aggregator.
// Depends on nothing but plain logic; field widths follow pea_pkg item types.
interface pea_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [1:0]         handle_id;
   logic [4:0]         ev_type;
   logic [9:0]         ev_code;
   logic signed [31:0] ev_value;
   logic               pointer_capable;

   modport source (output valid, req_type, handle_id, ev_type, ev_code, ev_value,
                   pointer_capable, input ready);
   modport sink (input valid, req_type, handle_id, ev_type, ev_code, ev_value,
                 pointer_capable, output ready);
endinterface

interface pea_rsp_if;
   logic               valid;
   logic               ready;
   logic               connected;
   logic [7:0]         device_total;
   logic               left_pressed;
   logic               right_pressed;
   logic               middle_pressed;
   logic signed [31:0] motion_x;
   logic signed [31:0] motion_y;
   logic signed [31:0] wheel_motion;
   logic               log_flag;
   logic               connect_ok;

   modport source (output valid, connected, device_total, left_pressed, right_pressed,
                   middle_pressed, motion_x, motion_y, wheel_motion, log_flag,
                   connect_ok, input ready);
   modport sink (input valid, connected, device_total, left_pressed, right_pressed,
                 middle_pressed, motion_x, motion_y, wheel_motion, log_flag,
                 connect_ok, output ready);
endinterface

>>> sv/pointer_event_aggregator.sv
// Pointer event aggregator top level: input register, status update, result register.
// Depends on pea_pkg, pea_if.sv and pointer_event_aggregator_assert.svh.
//
//   channel  | direction | carries
//   ---------+-----------+------------------------------------------------
//   req_bus  | in        | event, connect or disconnect item with handle
//   rsp_bus  | out       | one status snapshot item per request item
//
// An accepted item sits in the input register and, once the result register is free
// or being read, is applied to the status and shown from the result register; one
// item per clock is sustained while rsp_bus is not stalled, limited by the single status update.
// req_bus.ready drops only while both registers are full and rsp_bus is stalled.
// Synchronous reset clears the status, counts, sums and seen flags; the stored
// positions are not reset and are read only once their seen flag is set.
`include "pointer_event_aggregator_assert.svh"

module pointer_event_aggregator
   import pea_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   pea_req_if.sink  req_bus,
   pea_rsp_if.source rsp_bus
);

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   logic         s1_advance;
   logic         s1_fire;

   logic        active_ff, active_in;
   logic [7:0]  count_ff, count_in;
   logic [2:0]  btn_ff, btn_in;
   logic [31:0] sum_x_ff, sum_x_in;
   logic [31:0] sum_y_ff, sum_y_in;
   logic [31:0] sum_w_ff, sum_w_in;
   logic [31:0] lat_x_ff, lat_x_in;
   logic [31:0] lat_y_ff, lat_y_in;
   logic [31:0] lat_w_ff, lat_w_in;
   logic [SLOTS-1:0] seen_ff [MAX_HANDLES];
   logic [31:0]      pos_ff  [MAX_HANDLES][SLOTS];

   logic [1:0]  handle;
   logic [1:0]  slot;
   logic [1:0]  bit_idx;
   logic        recognized;
   logic        pressed;
   logic        changed;
   logic        log_out;
   logic        ok_out;
   logic        pos_we;
   logic        seen_we;
   logic [SLOTS-1:0] seen_val;
   logic [31:0] value;
   logic [31:0] pos_rd;
   logic [31:0] delta;
   logic        slot_seen;

   assign s1_advance    = !rsp_valid_ff || rsp_bus.ready;
   assign s1_fire       = s1_valid_ff && s1_advance;
   assign req_bus.ready = !s1_valid_ff || s1_advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_bus.valid && req_bus.ready) begin
         s1_item_ff.req_type        <= req_bus.req_type;
         s1_item_ff.handle_id       <= req_bus.handle_id;
         s1_item_ff.ev_type         <= req_bus.ev_type;
         s1_item_ff.ev_code         <= req_bus.ev_code;
         s1_item_ff.ev_value        <= req_bus.ev_value;
         s1_item_ff.pointer_capable <= req_bus.pointer_capable;
      end
   end

   assign handle    = s1_item_ff.handle_id;
   assign value     = s1_item_ff.ev_value;
   assign pos_rd    = pos_ff[handle][slot];
   assign slot_seen = seen_ff[handle][slot];
   assign delta     = value - pos_rd;
   assign pressed   = |value;

   // Decode the event code into a tracked position slot and a button bit.
   always_comb begin
      slot       = SLOT_ABS_X;
      bit_idx    = BIT_LEFT;
      recognized = 1'b0;
      unique case (s1_item_ff.ev_type)
         EV_SYN: begin
            recognized = (s1_item_ff.ev_code == SYN_FRAME);
         end
         EV_KEY: begin
            unique case (s1_item_ff.ev_code) inside
               BTN_PRIMARY, BTN_CONTACT, BTN_FINGER: begin
                  recognized = 1'b1;
                  bit_idx    = BIT_LEFT;
               end
               BTN_SECONDARY: begin
                  recognized = 1'b1;
                  bit_idx    = BIT_RIGHT;
               end
               BTN_MID: begin
                  recognized = 1'b1;
                  bit_idx    = BIT_MIDDLE;
               end
               default: recognized = 1'b0;
            endcase
         end
         EV_REL: begin
            recognized = (s1_item_ff.ev_code == REL_X) || (s1_item_ff.ev_code == REL_Y) ||
                         (s1_item_ff.ev_code == REL_SCROLL);
         end
         EV_ABS: begin
            unique case (s1_item_ff.ev_code)
               ABS_X: begin
                  recognized = 1'b1;
                  slot       = SLOT_ABS_X;
               end
               ABS_Y: begin
                  recognized = 1'b1;
                  slot       = SLOT_ABS_Y;
               end
               ABS_MT_X: begin
                  recognized = 1'b1;
                  slot       = SLOT_MT_X;
               end
               ABS_MT_Y: begin
                  recognized = 1'b1;
                  slot       = SLOT_MT_Y;
               end
               default: recognized = 1'b0;
            endcase
         end
         default: recognized = 1'b0;
      endcase
   end

   assign changed = (btn_ff[bit_idx] != pressed);

   always_comb begin
      active_in = active_ff;
      count_in  = count_ff;
      btn_in    = btn_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_w_in  = sum_w_ff;
      lat_x_in  = lat_x_ff;
      lat_y_in  = lat_y_ff;
      lat_w_in  = lat_w_ff;
      log_out   = 1'b0;
      ok_out    = 1'b0;
      pos_we    = 1'b0;
      seen_we   = 1'b0;
      seen_val  = seen_ff[handle];
      unique case (s1_item_ff.req_type)
         REQ_EVENT: begin
            if (recognized) begin
               active_in = 1'b1;
               unique case (s1_item_ff.ev_type)
                  EV_KEY: begin
                     if (changed) begin
                        btn_in[bit_idx] = pressed;
                        lat_x_in = '0;
                        lat_y_in = '0;
                        lat_w_in = '0;
                        log_out  = 1'b1;
                     end
                  end
                  EV_REL: begin
                     unique case (s1_item_ff.ev_code)
                        REL_X:   sum_x_in = sum_x_ff + value;
                        REL_Y:   sum_y_in = sum_y_ff + value;
                        default: sum_w_in = sum_w_ff + value;
                     endcase
                  end
                  EV_ABS: begin
                     // Motion counts only once the handle's previous position is known.
                     if (slot_seen) begin
                        if (slot[0]) begin
                           sum_y_in = sum_y_ff + delta;
                        end else begin
                           sum_x_in = sum_x_ff + delta;
                        end
                     end
                     pos_we         = 1'b1;
                     seen_we        = 1'b1;
                     seen_val[slot] = 1'b1;
                  end
                  default: begin
                     lat_x_in = sum_x_ff;
                     lat_y_in = sum_y_ff;
                     lat_w_in = sum_w_ff;
                     log_out  = |(sum_x_ff | sum_y_ff | sum_w_ff);
                     sum_x_in = '0;
                     sum_y_in = '0;
                     sum_w_in = '0;
                  end
               endcase
            end
         end
         REQ_CONNECT: begin
            if (s1_item_ff.pointer_capable) begin
               ok_out    = 1'b1;
               seen_we   = 1'b1;
               seen_val  = '0;
               count_in  = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;
               active_in = (count_in != 8'd0);
            end
         end
         REQ_DISCONNECT: begin
            count_in  = (count_ff == 8'd0) ? count_ff : count_ff - 8'd1;
            active_in = (count_in != 8'd0);
            if (count_in == 8'd0) begin
               btn_in   = '0;
               sum_x_in = '0;
               sum_y_in = '0;
               sum_w_in = '0;
               lat_x_in = '0;
               lat_y_in = '0;
               lat_w_in = '0;
            end
         end
         default: begin
            active_in = active_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         count_ff  <= '0;
         btn_ff    <= '0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_w_ff  <= '0;
         lat_x_ff  <= '0;
         lat_y_ff  <= '0;
         lat_w_ff  <= '0;
         for (int i = 0; i < MAX_HANDLES; i++) begin
            seen_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         active_ff <= active_in;
         count_ff  <= count_in;
         btn_ff    <= btn_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_w_ff  <= sum_w_in;
         lat_x_ff  <= lat_x_in;
         lat_y_ff  <= lat_y_in;
         lat_w_ff  <= lat_w_in;
         if (seen_we) begin
            seen_ff[handle] <= seen_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && pos_we) begin
         pos_ff[handle][slot] <= value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_item_ff.connected      <= active_in;
         rsp_item_ff.device_total   <= count_in;
         rsp_item_ff.left_pressed   <= btn_in[BIT_LEFT];
         rsp_item_ff.right_pressed  <= btn_in[BIT_RIGHT];
         rsp_item_ff.middle_pressed <= btn_in[BIT_MIDDLE];
         rsp_item_ff.motion_x       <= lat_x_in;
         rsp_item_ff.motion_y       <= lat_y_in;
         rsp_item_ff.wheel_motion   <= lat_w_in;
         rsp_item_ff.log_flag       <= log_out;
         rsp_item_ff.connect_ok     <= ok_out;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.connected      = rsp_item_ff.connected;
   assign rsp_bus.device_total   = rsp_item_ff.device_total;
   assign rsp_bus.left_pressed   = rsp_item_ff.left_pressed;
   assign rsp_bus.right_pressed  = rsp_item_ff.right_pressed;
   assign rsp_bus.middle_pressed = rsp_item_ff.middle_pressed;
   assign rsp_bus.motion_x       = rsp_item_ff.motion_x;
   assign rsp_bus.motion_y       = rsp_item_ff.motion_y;
   assign rsp_bus.wheel_motion   = rsp_item_ff.wheel_motion;
   assign rsp_bus.log_flag       = rsp_item_ff.log_flag;
   assign rsp_bus.connect_ok     = rsp_item_ff.connect_ok;

   // An inactive status only arises from reset or the last disconnect, both of
   // which leave buttons, sums and latched motion cleared.
   `PEA_ASSERT_NOW(a_idle_is_clear, !active_ff,
      (btn_ff == 3'd0) && (sum_x_ff == 32'd0) && (sum_y_ff == 32'd0) && (sum_w_ff == 32'd0)
      && (lat_x_ff == 32'd0) && (lat_y_ff == 32'd0) && (lat_w_ff == 32'd0),
      "status inactive while motion or buttons are set")
   `PEA_ASSERT_NOW(a_connect_counts, rsp_valid_ff && rsp_item_ff.connect_ok,
      rsp_item_ff.connected && (rsp_item_ff.device_total != 8'd0),
      "accepted connect left no device counted")
   `PEA_ASSERT_NOW(a_log_not_on_connect, rsp_valid_ff,
      !(rsp_item_ff.log_flag && rsp_item_ff.connect_ok),
      "log flag raised on a connect item")
   `PEA_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_item_ff),
      "input register lost an item while the result side stalled")

endmodule

>>> tb/sv/pointer_event_aggregator_test.sv
// Self-checking test of pointer_event_aggregator: directed and random event, connect
// and disconnect items, with a local status predictor checked against every result.
// Depends on pea_pkg, pea_if.sv and the pointer_event_aggregator RTL.
module pointer_event_aggregator_test;
   import pea_pkg::*;

   localparam logic [1:0] REQ_UNUSED      = 2'd3;
   localparam logic [9:0] REL_UNUSED_CODE = 10'd2;
   localparam logic [9:0] KEY_UNUSED_CODE = 10'd275;
   localparam int STALL_LIMIT = 1000;
   localparam int LONG_HOLD   = 60;

   typedef struct {
      req_item_type item;
      int unsigned  gap;
   } pending_req_type;

   logic clock;
   logic reset;

   pea_req_if req_ch ();
   pea_rsp_if rsp_ch ();

   pointer_event_aggregator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   // Predicted pointer status.
   logic        active_now = 1'b0;
   logic [7:0]  devices = '0;
   logic [2:0]  buttons = '0;
   logic [31:0] sum_dx = '0, sum_dy = '0, sum_wheel = '0;
   logic [31:0] shown_dx = '0, shown_dy = '0, shown_wheel = '0;
   logic [31:0] last_pos [MAX_HANDLES][SLOTS];
   logic [SLOTS-1:0] pos_seen [MAX_HANDLES] = '{default: '0};

   pending_req_type req_queue [$];
   rsp_item_type    status_queue [$];
   pending_req_type next_entry;
   req_item_type    taken_item;
   rsp_item_type    seen_status, want_status;

   int unsigned items_queued = 0;
   int unsigned items_accepted = 0;
   int unsigned mismatch_count = 0;
   int unsigned stuck_cycles = 0;
   int unsigned gap_count = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   bit          req_fire = 0;
   bit          rsp_fire = 0;
   bit          idle_on = 1;
   bit          hold_request = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Applies one request item to the predicted status and returns the snapshot it yields.
   function automatic rsp_item_type apply_pointer_item(req_item_type it);
      rsp_item_type snap;
      logic         known, logged, ok, pressed;
      logic [1:0]   bpos, slot;
      logic [31:0]  v, step;
      int unsigned  h;
      known = 1'b0;
      logged = 1'b0;
      ok = 1'b0;
      bpos = BIT_LEFT;
      slot = SLOT_ABS_X;
      h = it.handle_id % MAX_HANDLES;
      v = it.ev_value;
      case (it.req_type)
         REQ_EVENT: begin
            case (it.ev_type)
               EV_SYN: known = (it.ev_code == SYN_FRAME);
               EV_KEY: begin
                  known = 1'b1;
                  if (it.ev_code == BTN_PRIMARY || it.ev_code == BTN_CONTACT ||
                      it.ev_code == BTN_FINGER) bpos = BIT_LEFT;
                  else if (it.ev_code == BTN_SECONDARY) bpos = BIT_RIGHT;
                  else if (it.ev_code == BTN_MID) bpos = BIT_MIDDLE;
                  else known = 1'b0;
               end
               EV_REL: known = (it.ev_code == REL_X || it.ev_code == REL_Y ||
                                it.ev_code == REL_SCROLL);
               EV_ABS: begin
                  known = 1'b1;
                  if (it.ev_code == ABS_X) slot = SLOT_ABS_X;
                  else if (it.ev_code == ABS_Y) slot = SLOT_ABS_Y;
                  else if (it.ev_code == ABS_MT_X) slot = SLOT_MT_X;
                  else if (it.ev_code == ABS_MT_Y) slot = SLOT_MT_Y;
                  else known = 1'b0;
               end
               default: known = 1'b0;
            endcase
            if (known) begin
               active_now = 1'b1;
               case (it.ev_type)
                  EV_SYN: begin
                     shown_dx = sum_dx;
                     shown_dy = sum_dy;
                     shown_wheel = sum_wheel;
                     logged = |(sum_dx | sum_dy | sum_wheel);
                     sum_dx = '0;
                     sum_dy = '0;
                     sum_wheel = '0;
                  end
                  EV_KEY: begin
                     pressed = (v != 0);
                     // A button change blanks the reported motion.
                     if (buttons[bpos] != pressed) begin
                        buttons[bpos] = pressed;
                        shown_dx = '0;
                        shown_dy = '0;
                        shown_wheel = '0;
                        logged = 1'b1;
                     end
                  end
                  EV_REL: begin
                     if (it.ev_code == REL_X) sum_dx += v;
                     else if (it.ev_code == REL_Y) sum_dy += v;
                     else sum_wheel += v;
                  end
                  default: begin
                     // Positions only contribute once the previous one is known.
                     if (pos_seen[h][slot]) begin
                        step = v - last_pos[h][slot];
                        if (slot == SLOT_ABS_Y || slot == SLOT_MT_Y) sum_dy += step;
                        else sum_dx += step;
                     end
                     last_pos[h][slot] = v;
                     pos_seen[h][slot] = 1'b1;
                  end
               endcase
            end
         end
         REQ_CONNECT: begin
            if (it.pointer_capable) begin
               ok = 1'b1;
               pos_seen[h] = '0;
               if (devices != COUNT_MAX) devices++;
               active_now = 1'b1;
            end
         end
         REQ_DISCONNECT: begin
            if (devices != 0) devices--;
            active_now = (devices != 0);
            if (!active_now) begin
               buttons = '0;
               shown_dx = '0;
               shown_dy = '0;
               shown_wheel = '0;
               sum_dx = '0;
               sum_dy = '0;
               sum_wheel = '0;
            end
         end
         default: ;
      endcase
      snap.connected = active_now;
      snap.device_total = devices;
      snap.left_pressed = buttons[BIT_LEFT];
      snap.right_pressed = buttons[BIT_RIGHT];
      snap.middle_pressed = buttons[BIT_MIDDLE];
      snap.motion_x = shown_dx;
      snap.motion_y = shown_dy;
      snap.wheel_motion = shown_wheel;
      snap.log_flag = logged;
      snap.connect_ok = ok;
      return snap;
   endfunction

   function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   // Handshakes are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         taken_item.req_type = req_ch.req_type;
         taken_item.handle_id = req_ch.handle_id;
         taken_item.ev_type = req_ch.ev_type;
         taken_item.ev_code = req_ch.ev_code;
         taken_item.ev_value = req_ch.ev_value;
         taken_item.pointer_capable = req_ch.pointer_capable;
         status_queue.push_back(apply_pointer_item(taken_item));
         items_accepted++;
         req_fire = 1'b1;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_fire = 1'b1;
         seen_status.connected = rsp_ch.connected;
         seen_status.device_total = rsp_ch.device_total;
         seen_status.left_pressed = rsp_ch.left_pressed;
         seen_status.right_pressed = rsp_ch.right_pressed;
         seen_status.middle_pressed = rsp_ch.middle_pressed;
         seen_status.motion_x = rsp_ch.motion_x;
         seen_status.motion_y = rsp_ch.motion_y;
         seen_status.wheel_motion = rsp_ch.wheel_motion;
         seen_status.log_flag = rsp_ch.log_flag;
         seen_status.connect_ok = rsp_ch.connect_ok;
         if (status_queue.size() == 0) begin
            $display("%0t: unexpected result item: expected none, actual total %0d",
                     $time, seen_status.device_total);
            mismatch_count++;
         end else begin
            want_status = status_queue.pop_front();
            compare_field("connected", 32'(want_status.connected),
                          32'(seen_status.connected));
            compare_field("device_total", 32'(want_status.device_total),
                          32'(seen_status.device_total));
            compare_field("left_pressed", 32'(want_status.left_pressed),
                          32'(seen_status.left_pressed));
            compare_field("right_pressed", 32'(want_status.right_pressed),
                          32'(seen_status.right_pressed));
            compare_field("middle_pressed", 32'(want_status.middle_pressed),
                          32'(seen_status.middle_pressed));
            compare_field("motion_x", want_status.motion_x, seen_status.motion_x);
            compare_field("motion_y", want_status.motion_y, seen_status.motion_y);
            compare_field("wheel_motion", want_status.wheel_motion, seen_status.wheel_motion);
            compare_field("log_flag", 32'(want_status.log_flag), 32'(seen_status.log_flag));
            compare_field("connect_ok", 32'(want_status.connect_ok),
                          32'(seen_status.connect_ok));
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
   end

   // Request driver: the next item goes out once the current one is taken and its gap is over.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.req_type <= '0;
         req_ch.handle_id <= '0;
         req_ch.ev_type <= '0;
         req_ch.ev_code <= '0;
         req_ch.ev_value <= '0;
         req_ch.pointer_capable <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_queue.size() != 0 && gap_count >= req_queue[0].gap) begin
            next_entry = req_queue.pop_front();
            gap_count = 0;
            req_ch.valid <= 1'b1;
            req_ch.req_type <= next_entry.item.req_type;
            req_ch.handle_id <= next_entry.item.handle_id;
            req_ch.ev_type <= next_entry.item.ev_type;
            req_ch.ev_code <= next_entry.item.ev_code;
            req_ch.ev_value <= next_entry.item.ev_value;
            req_ch.pointer_capable <= next_entry.item.pointer_capable;
         end else begin
            req_ch.valid <= 1'b0;
            if (req_queue.size() != 0) gap_count++;
         end
      end
      req_fire = 1'b0;
   end

   // Result receiver: a random stall after each item while idling is on, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = LONG_HOLD;
            hold_request = 0;
         end
         if (rsp_fire) stall_left = idle_on ? $urandom_range(0, 4) : 0;
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
      rsp_fire = 1'b0;
   end

   initial begin
      while (stuck_cycles < STALL_LIMIT) @(posedge clock);
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("** pointer_event_aggregator: FAILED **");
      $finish;
   end

   task automatic queue_item(logic [1:0] kind, logic [1:0] h, logic [4:0] t, logic [9:0] c,
                             logic [31:0] v, logic cap);
      pending_req_type e;
      e.item.req_type = kind;
      e.item.handle_id = h;
      e.item.ev_type = t;
      e.item.ev_code = c;
      e.item.ev_value = v;
      e.item.pointer_capable = cap;
      e.gap = idle_on ? $urandom_range(0, 4) : 0;
      req_queue.push_back(e);
      items_queued++;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3: return $urandom;
         default: return $urandom_range(0, 127) - 64;
      endcase
   endfunction

   // One frame: one to six items, mostly motion or button events on one handle, usually closed by a report.
   task automatic queue_frame();
      int unsigned n, pick;
      logic [1:0]  h;
      logic [9:0]  code;
      logic [31:0] press;
      h = 2'($urandom_range(0, 3));
      n = $urandom_range(1, 6);
      repeat (n) begin
         pick = $urandom_range(0, 19);
         if (pick < 4) begin
            case ($urandom_range(0, 2))
               0: code = REL_X;
               1: code = REL_Y;
               default: code = REL_SCROLL;
            endcase
            queue_item(REQ_EVENT, h, EV_REL, code, pick_value(), 1'($urandom_range(0, 1)));
         end else if (pick < 12) begin
            case ($urandom_range(0, 3))
               0: code = ABS_X;
               1: code = ABS_Y;
               2: code = ABS_MT_X;
               default: code = ABS_MT_Y;
            endcase
            queue_item(REQ_EVENT, h, EV_ABS, code, pick_value(), 1'($urandom_range(0, 1)));
         end else if (pick < 16) begin
            case ($urandom_range(0, 4))
               0: code = BTN_PRIMARY;
               1: code = BTN_SECONDARY;
               2: code = BTN_MID;
               3: code = BTN_FINGER;
               default: code = BTN_CONTACT;
            endcase
            case ($urandom_range(0, 2))
               0: press = '0;
               1: press = 32'd1;
               default: press = $urandom;
            endcase
            queue_item(REQ_EVENT, h, EV_KEY, code, press, 1'($urandom_range(0, 1)));
         end else if (pick < 18) begin
            queue_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)), $urandom,
                       1'($urandom_range(0, 1)));
         end else if (pick == 18) begin
            queue_item(REQ_CONNECT, h, EV_SYN, SYN_FRAME, '0, $urandom_range(0, 3) != 0);
         end else begin
            queue_item(REQ_DISCONNECT, h, EV_SYN, SYN_FRAME, '0, 1'($urandom_range(0, 1)));
         end
      end
      if ($urandom_range(0, 9) != 0)
         queue_item(REQ_EVENT, h, EV_SYN, SYN_FRAME, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (items_accepted != items_queued || status_queue.size() != 0);
   endtask

   initial begin
      int unsigned caps, chunk;
      bit          cap;
      caps = 0;

      // Directed part.
      queue_item(REQ_UNUSED, 2'd3, EV_SYN, SYN_FRAME, '0, 1'b1);
      queue_item(REQ_DISCONNECT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_REL, REL_UNUSED_CODE, 32'd5, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_REL, REL_X, 32'h7fff_ffff, 1'b0);
      queue_item(REQ_CONNECT, 2'd1, EV_SYN, SYN_FRAME, '0, 1'b0);
      queue_item(REQ_CONNECT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b1);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_X, 32'd100, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_X, 32'h8000_0000, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_Y, 32'hffff_fffb, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_Y, 32'h7fff_ffff, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_MT_X, 32'd7, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_MT_X, 32'd9, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_MT_Y, 32'd1, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_REL, REL_Y, 32'h8000_0000, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_REL, REL_SCROLL, 32'hffff_ffff, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b0);
      queue_item(REQ_EVENT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_PRIMARY, 32'd1, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_PRIMARY, 32'd5, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_CONTACT, '0, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_FINGER, 32'hffff_ffff, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_SECONDARY, 32'd1, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, BTN_MID, 32'h8000_0000, 1'b0);
      queue_item(REQ_EVENT, 2'd2, EV_KEY, KEY_UNUSED_CODE, 32'd1, 1'b0);
      queue_item(REQ_CONNECT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b1);
      queue_item(REQ_EVENT, 2'd0, EV_ABS, ABS_X, 32'd50, 1'b0);
      queue_item(REQ_DISCONNECT, 2'd3, EV_SYN, SYN_FRAME, '0, 1'b1);
      queue_item(REQ_DISCONNECT, 2'd0, EV_SYN, SYN_FRAME, '0, 1'b0);
      wait_drained();

      // Random frames, alternating stretches with and without idling.
      for (chunk = 0; chunk < 5; chunk++) begin
         idle_on = chunk[0];
         repeat (6) queue_frame();
         wait_drained();
      end

      // Back-to-back items against a long receiver hold-off fill the block.
      idle_on = 0;
      hold_request = 1;
      repeat (6) queue_frame();
      wait_drained();

      // Enough accepted connects to saturate the device count, then drain it past zero.
      idle_on = 1;
      while (caps < 260) begin
         cap = ($urandom_range(0, 9) != 0);
         queue_item(REQ_CONNECT, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                    10'($urandom_range(0, 1023)), $urandom, cap);
         if (cap) caps++;
      end
      repeat (12) queue_frame();
      repeat (262)
         queue_item(REQ_DISCONNECT, 2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                    10'($urandom_range(0, 1023)), $urandom, 1'($urandom_range(0, 1)));
      repeat (6) queue_frame();
      wait_drained();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && status_queue.size() == 0) begin
         $display("** pointer_event_aggregator: PASSED **");
      end else begin
         $display("** pointer_event_aggregator: FAILED **");
      end
      $finish;
   end

endmodule
